// ----- hdl/zmvt_pkg.sv -----
package zmvt_pkg;

    localparam int OP_W  = 2;
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    typedef logic [OP_W-1:0]         opcode_t;
    typedef logic [IDX_W-1:0]        index_t;
    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [ST_W-1:0]         status_t;

    localparam opcode_t OP_FIND   = 2'd0;
    localparam opcode_t OP_WRITE  = 2'd1;
    localparam opcode_t OP_ADD    = 2'd2;
    localparam opcode_t OP_REMOVE = 2'd3;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NOTFOUND = 2'd1;
    localparam status_t ST_RANGE    = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

    typedef struct packed {
        status_t status;
        index_t  slot_index;
        value_t  old_value;
    } result_t;

    // one access on the single memory port per cycle: read, or write when we is set
    typedef struct packed {
        logic   en;
        logic   we;
        index_t addr;
        value_t wdata;
    } mem_req_t;

endpackage

// ----- hdl/zmvt_req_if.sv -----
interface zmvt_req_if;
    import zmvt_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    index_t  index;
    value_t  value;

    modport source (output valid, output opcode, output index, output value, input ready);
    modport sink (input valid, input opcode, input index, input value, output ready);

endinterface

// ----- hdl/zmvt_rsp_if.sv -----
interface zmvt_rsp_if;
    import zmvt_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    index_t  slot_index;
    value_t  old_value;

    modport source (output valid, output status, output slot_index, output old_value,
                    input ready);
    modport sink (input valid, input status, input slot_index, input old_value,
                  output ready);

endinterface

// ----- hdl/zero_marked_value_table.sv -----
// Zero-marked value table: ENTRIES signed 32-bit slots in one single-port
// synchronous memory, where a slot holding zero counts as empty. Each request
// beat on req carries an opcode and yields exactly one response beat on rsp:
// find returns the lowest slot equal to the key (a key of zero finds the
// lowest empty slot), write stores at an index and returns the old value, add
// fills the lowest empty slot or reports full, remove zeroes an index and
// returns the old value; write and remove flag an index not below ENTRIES.
// After reset the block clears the memory one entry per cycle and takes no
// request until the clearing pass is done. One request is in work at a time:
// find and add walk the memory one entry per cycle until an entry decides the
// outcome or the last entry has been compared; write and remove read the
// slot, write it back and then give the result, while an out of range index
// goes straight to the result. A registered response stage lets the next
// request enter while a response is still waiting on rsp.ready.
module zero_marked_value_table #(
    parameter int ENTRIES = 256
) (
    input logic        clk,
    input logic        rst_n,
    zmvt_req_if.sink   req,
    zmvt_rsp_if.source rsp
);
    import zmvt_pkg::*;

    mem_req_t mem_req;
    value_t   mem_rdata;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic     out_valid_reg;
    result_t  out_reg;

    // Sequencer: clearing pass, scan, read-modify-write.
    zmvt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Slot storage, one access per cycle.
    zmvt_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Take a new result when the output stage is empty or being drained.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            // drop the beat once it has been taken
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the response payload until a new result replaces it.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.slot_index = out_reg.slot_index;
    assign rsp.old_value  = out_reg.old_value;

endmodule

// ----- hdl/zmvt_store.sv -----
module zmvt_store #(
    parameter int ENTRIES = 256
) (
    input  logic               clk,
    input  zmvt_pkg::mem_req_t req,
    output zmvt_pkg::value_t   rdata
);
    import zmvt_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    value_t mem [ENTRIES];
    value_t rdata_reg;

    // single port, read data registered
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr[AW-1:0]] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr[AW-1:0]];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/zmvt_ctrl.sv -----
module zmvt_ctrl #(
    parameter int ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    zmvt_req_if.sink           req,
    output zmvt_pkg::mem_req_t mem_req,
    input  zmvt_pkg::value_t   mem_rdata,
    output logic               res_valid,
    input  logic               res_ready,
    output zmvt_pkg::result_t  res
);
    import zmvt_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] ADDR_LAST = AW'(ENTRIES - 1);
    localparam logic [IDX_W:0] ENTRIES_EXT = (IDX_W + 1)'(ENTRIES);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_RMW    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    opcode_t       op_reg, op_next;
    value_t        value_reg, value_next;
    result_t       res_reg, res_next;

    logic in_range;
    logic hit;

    assign in_range = ({1'b0, req.index} < ENTRIES_EXT);
    // find compares against the key, add looks for an empty slot
    assign hit = (op_reg == OP_FIND) ? (mem_rdata == value_reg) : (mem_rdata == '0);

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        op_next    = op_reg;
        value_next = value_reg;
        res_next   = res_reg;
        mem_req    = '0;
        req.ready  = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = IDX_W'(addr_reg);
                if (addr_reg == ADDR_LAST)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    value_next = req.value;
                    unique case (req.opcode)
                        OP_FIND, OP_ADD:
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = '0;
                            addr_next    = '0;
                            state_next   = S_SCAN;
                        end
                        default:
                        begin
                            if (!in_range)
                            begin
                                res_next   = '{status: ST_RANGE, slot_index: '0, old_value: '0};
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                mem_req.en   = 1'b1;
                                mem_req.addr = req.index;
                                addr_next    = req.index[AW-1:0];
                                state_next   = S_RMW;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_next = '{status: ST_OK, slot_index: IDX_W'(addr_reg), old_value: '0};
                    if (op_reg == OP_ADD)
                    begin
                        mem_req.en    = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.addr  = IDX_W'(addr_reg);
                        mem_req.wdata = value_reg;
                    end
                    state_next = S_RESULT;
                end
                else if (addr_reg == ADDR_LAST)
                begin
                    res_next.status     = (op_reg == OP_FIND) ? ST_NOTFOUND : ST_FULL;
                    res_next.slot_index = '0;
                    res_next.old_value  = '0;
                    state_next          = S_RESULT;
                end
                else
                begin
                    // fetch the next entry while this one is compared
                    mem_req.en   = 1'b1;
                    mem_req.addr = IDX_W'(addr_reg + 1'b1);
                    addr_next    = addr_reg + 1'b1;
                end
            end
            S_RMW:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = IDX_W'(addr_reg);
                mem_req.wdata = (op_reg == OP_WRITE) ? value_reg : '0;
                res_next      = '{status: ST_OK, slot_index: '0, old_value: mem_rdata};
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                addr_next  = '0;
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

    // only an add may write during a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && mem_req.we) |-> (op_reg == OP_ADD))
        else $error("scan wrote memory for an op other than add");

    // a scan never runs past the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ({1'b0, IDX_W'(addr_reg)} < ENTRIES_EXT))
        else $error("scan address beyond table");

    // out-of-range status only for write or remove
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_RANGE) |-> (op_reg == OP_WRITE || op_reg == OP_REMOVE))
        else $error("range status for find or add");

    // a delivered result returns the controller to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after result");

endmodule
